[rtl/psbb_pkg.sv]
// Shared types and constants of the page shift bitmap blitter.
package psbb_pkg;

  localparam int unsigned AddrW    = 10;
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = 2;

  typedef enum logic [2:0] {
    CfgDestX,
    CfgDestY,
    CfgSrcWidth,
    CfgSrcPages,
    CfgBlendMode
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BlendOr  = 2'd0,
    BlendClr = 2'd1,
    BlendRep = 2'd2
  } blend_e;

  typedef struct packed {
    logic [7:0] dest_x;
    logic [6:0] dest_y;
    logic [7:0] src_width;
    logic [3:0] src_pages;
    logic [1:0] blend_mode;
  } cfg_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [7:0]       value;
  } put_t;

  typedef struct packed {
    put_t op0;
    put_t op1;
    logic two;
  } pair_t;

endpackage

[rtl/psbb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module psbb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 504,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/psbb_front.sv]
// Front end: column/row tracking, vertical shift, clipping and address generation.
module psbb_front #(
  parameter int unsigned DISPLAY_WIDTH = 84,
  parameter int unsigned DISPLAY_PAGES = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psbb_pkg::cfg_t      cfg_i,
  input  logic                accept_i,
  input  logic [7:0]          src_byte_i,
  input  logic                last_in_column_i,
  input  logic                first_of_image_i,
  output psbb_pkg::pair_t     pair_o,
  output logic                pair_valid_o
);

  logic [7:0] cc_q, cc_d;
  logic [3:0] rc_q, rc_d;
  logic [7:0] cy_q, cy_d;
  logic [7:0] held_q, held_d;
  logic       hv_q, hv_d;

  logic [7:0] cc, cy;
  logic [3:0] rc;
  logic       hv, active, colend, y_neg;
  logic [6:0] ny;
  logic [2:0] bo, offp;
  logic [3:0] offn;
  logic [9:0] col;
  logic [5:0] s6;
  logic       col_ok;
  logic       a_v, b_v, a_ok, b_ok;
  logic [5:0] a_pg, b_pg;
  logic [7:0] a_val, b_val, carry_n, held_n;
  logic       hv_n;
  psbb_pkg::put_t a_put, b_put;

  always_comb begin
    cc = first_of_image_i ? 8'd0 : cc_q;
    rc = first_of_image_i ? 4'd0 : rc_q;
    cy = first_of_image_i ? 8'd0 : cy_q;
    hv = first_of_image_i ? 1'b0 : hv_q;

    active = cc < cfg_i.src_width;
    colend = last_in_column_i || (({1'b0, rc} + 5'd1) >= {1'b0, cfg_i.src_pages});

    y_neg = cfg_i.dest_y[6];
    ny    = ~cfg_i.dest_y + 7'd1;
    offp  = cfg_i.dest_y[5:3];
    offn  = ny[6:3];
    bo    = y_neg ? ny[2:0] : cfg_i.dest_y[2:0];

    col = {{2{cfg_i.dest_x[7]}}, cfg_i.dest_x} + {2'b00, cc};
    s6  = {2'b00, rc};

    a_v     = 1'b0;
    b_v     = 1'b0;
    a_pg    = 6'd0;
    b_pg    = 6'd0;
    a_val   = 8'd0;
    b_val   = 8'd0;
    carry_n = cy;
    held_n  = held_q;
    hv_n    = hv;

    if (!y_neg) begin
      a_v   = 1'b1;
      a_pg  = {3'b000, offp} + s6;
      a_val = cy | (src_byte_i << bo);
      if (bo != 3'd0) begin
        carry_n = src_byte_i >> (4'd8 - {1'b0, bo});
        b_v     = colend;
        b_pg    = a_pg + 6'd1;
        b_val   = carry_n;
      end else begin
        carry_n = 8'd0;
      end
    end else if (bo == 3'd0) begin
      a_v   = 1'b1;
      a_pg  = s6 - {2'b00, offn};
      a_val = src_byte_i;
    end else begin
      a_v    = hv;
      a_pg   = s6 - 6'd1 - {2'b00, offn};
      a_val  = (held_q >> bo) | (src_byte_i << (4'd8 - {1'b0, bo}));
      held_n = src_byte_i;
      hv_n   = 1'b1;
      b_v    = colend;
      b_pg   = s6 - {2'b00, offn};
      b_val  = src_byte_i >> bo;
    end

    col_ok = !col[9] && (col[8:0] < 9'(DISPLAY_WIDTH));
    a_ok   = active && a_v && col_ok && !a_pg[5] && (a_pg[4:0] < 5'(DISPLAY_PAGES));
    b_ok   = active && b_v && col_ok && !b_pg[5] && (b_pg[4:0] < 5'(DISPLAY_PAGES));

    a_put.addr  = 10'({3'b000, col[6:0]} * 10'(DISPLAY_PAGES)) + {5'b00000, a_pg[4:0]};
    a_put.value = a_val;
    b_put.addr  = 10'({3'b000, col[6:0]} * 10'(DISPLAY_PAGES)) + {5'b00000, b_pg[4:0]};
    b_put.value = b_val;

    pair_o.op0   = a_ok ? a_put : b_put;
    pair_o.op1   = b_put;
    pair_o.two   = a_ok && b_ok;
    pair_valid_o = accept_i && (a_ok || b_ok);

    cc_d   = cc;
    rc_d   = rc;
    cy_d   = cy;
    hv_d   = hv;
    held_d = held_q;
    if (active) begin
      cy_d   = carry_n;
      held_d = held_n;
      hv_d   = hv_n;
      if (colend) begin
        cc_d = cc + 8'd1;
        rc_d = 4'd0;
        cy_d = 8'd0;
        hv_d = 1'b0;
      end else begin
        rc_d = rc + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= 8'd0;
      rc_q   <= 4'd0;
      cy_q   <= 8'd0;
      held_q <= 8'd0;
      hv_q   <= 1'b0;
    end else if (accept_i) begin
      cc_q   <= cc_d;
      rc_q   <= rc_d;
      cy_q   <= cy_d;
      held_q <= held_d;
      hv_q   <= hv_d;
    end
  end

endmodule

[rtl/psbb_opq.sv]
// Two-entry queue of write pairs between front end and back end.
module psbb_opq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  psbb_pkg::pair_t pair_i,
  output logic            full_o,
  output logic            valid_o,
  output psbb_pkg::pair_t head_o,
  input  logic            pop_i
);

  psbb_pkg::pair_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

[rtl/psbb_back.sv]
// Back end: framebuffer clear pass, read-modify-write and result queue.
module psbb_back #(
  parameter int unsigned Depth = 504
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   blend_mode_i,
  input  logic                         head_valid_i,
  input  psbb_pkg::pair_t              head_i,
  output logic                         head_pop_o,
  output logic                         clearing_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [psbb_pkg::AddrW-1:0]   fb_address_o,
  output logic [7:0]                   fb_value_o,
  output logic                         last_o
);

  localparam int unsigned AW = $clog2(Depth);

  typedef struct packed {
    logic [psbb_pkg::AddrW-1:0] addr;
    logic [7:0]                 value;
    logic                       last;
  } res_t;

  logic                       clearing_q;
  logic [AW-1:0]              clr_addr_q;
  logic                       sel_q;
  logic                       b_valid_q, b_last_q;
  logic [psbb_pkg::AddrW-1:0] b_addr_q;
  logic [7:0]                 b_val_q;
  logic                       fw_valid_q;
  logic [psbb_pkg::AddrW-1:0] fw_addr_q;
  logic [7:0]                 fw_data_q;

  res_t                          oq_q [psbb_pkg::OutDepth];
  logic [psbb_pkg::OutPtrW-1:0]  oq_wr_q, oq_rd_q;
  logic [psbb_pkg::OutPtrW:0]    oq_cnt_q;

  psbb_pkg::put_t cur;
  logic           last_of_entry, issue, oq_pop;
  logic [7:0]     rd_data, old, nv;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;

  always_comb begin
    cur           = sel_q ? head_i.op1 : head_i.op0;
    last_of_entry = sel_q || !head_i.two;
    issue         = !clearing_q && head_valid_i &&
                    (({1'b0, oq_cnt_q} + {{(psbb_pkg::OutPtrW + 1){1'b0}}, b_valid_q}) <
                     (psbb_pkg::OutPtrW + 2)'(psbb_pkg::OutDepth));
    head_pop_o    = issue && last_of_entry;

    old = (fw_valid_q && (fw_addr_q == b_addr_q)) ? fw_data_q : rd_data;
    unique case (blend_mode_i)
      psbb_pkg::BlendOr:  nv = old | b_val_q;
      psbb_pkg::BlendClr: nv = old & ~b_val_q;
      psbb_pkg::BlendRep: nv = b_val_q;
      default:            nv = old;
    endcase

    ram_we    = clearing_q || b_valid_q;
    ram_waddr = clearing_q ? clr_addr_q : b_addr_q[AW-1:0];
    ram_wdata = clearing_q ? 8'd0 : nv;

    oq_pop = pop_i && !empty_o;
  end

  psbb_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_fb (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cur.addr[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_addr_q <= cur.addr;
      b_val_q  <= cur.value;
      b_last_q <= last_of_entry;
    end
    if (b_valid_q) begin
      fw_addr_q <= b_addr_q;
      fw_data_q <= nv;
      oq_q[oq_wr_q] <= '{addr: b_addr_q, value: nv, last: b_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      sel_q      <= 1'b0;
      b_valid_q  <= 1'b0;
      fw_valid_q <= 1'b0;
      oq_wr_q    <= '0;
      oq_rd_q    <= '0;
      oq_cnt_q   <= '0;
    end else begin
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(Depth - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (issue) begin
        sel_q <= !last_of_entry;
      end
      b_valid_q <= issue;
      if (b_valid_q) begin
        fw_valid_q <= 1'b1;
        oq_wr_q    <= oq_wr_q + psbb_pkg::OutPtrW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + psbb_pkg::OutPtrW'(1);
      end
      oq_cnt_q <= oq_cnt_q + (psbb_pkg::OutPtrW + 1)'(b_valid_q) -
                  (psbb_pkg::OutPtrW + 1)'(oq_pop);
    end
  end

  assign clearing_o   = clearing_q;
  assign empty_o      = oq_cnt_q == '0;
  assign fb_address_o = oq_q[oq_rd_q].addr;
  assign fb_value_o   = oq_q[oq_rd_q].value;
  assign last_o       = oq_q[oq_rd_q].last;

`ifndef SYNTHESIS
  a_oq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (oq_cnt_q < (psbb_pkg::OutPtrW + 1)'(psbb_pkg::OutDepth)))
    else $error("result queue overflow");
  a_no_rmw_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !b_valid_q && !issue)
    else $error("framebuffer access during clear pass");
  a_addr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (b_addr_q < psbb_pkg::AddrW'(Depth)))
    else $error("framebuffer address out of range");
  a_clear_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> empty_o && !b_valid_q)
    else $error("results present at end of clear pass");
`endif

endmodule

[rtl/page_shift_bitmap_blitter.sv]
// Top level of the page shift bitmap blitter: config registers and front/back wiring.
// Path: pair queue, then read-modify-write stage, then result queue.
// Throughput: one framebuffer write per cycle on the single RAM write port while the
// result queue has room and no clear pass runs; a byte's two writes issue in turn.
// Reset: the framebuffer is zeroed by a pass over all DISPLAY_WIDTH*DISPLAY_PAGES
// addresses; full stays high during it while config writes are taken.
module page_shift_bitmap_blitter #(
  parameter int unsigned DISPLAY_WIDTH = 84,
  parameter int unsigned DISPLAY_PAGES = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 src_byte_i,
  input  logic                       last_in_column_i,
  input  logic                       first_of_image_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [psbb_pkg::AddrW-1:0] fb_address_o,
  output logic [7:0]                 fb_value_o,
  output logic                       last_o,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [7:0]                 cfg_data_i
);

  psbb_pkg::cfg_t  cfg_q;
  psbb_pkg::pair_t pair, head;
  logic            pair_valid, opq_full, head_valid, head_pop, clearing, accept;

  assign full   = clearing || opq_full;
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x     <= 8'd0;
      cfg_q.dest_y     <= 7'd0;
      cfg_q.src_width  <= 8'd1;
      cfg_q.src_pages  <= 4'd1;
      cfg_q.blend_mode <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psbb_pkg::CfgDestX:     cfg_q.dest_x     <= cfg_data_i;
        psbb_pkg::CfgDestY:     cfg_q.dest_y     <= cfg_data_i[6:0];
        psbb_pkg::CfgSrcWidth:  cfg_q.src_width  <= cfg_data_i;
        psbb_pkg::CfgSrcPages:  cfg_q.src_pages  <= cfg_data_i[3:0];
        psbb_pkg::CfgBlendMode: cfg_q.blend_mode <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  psbb_front #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_PAGES (DISPLAY_PAGES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .accept_i         (accept),
    .src_byte_i       (src_byte_i),
    .last_in_column_i (last_in_column_i),
    .first_of_image_i (first_of_image_i),
    .pair_o           (pair),
    .pair_valid_o     (pair_valid)
  );

  psbb_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pair_valid),
    .pair_i  (pair),
    .full_o  (opq_full),
    .valid_o (head_valid),
    .head_o  (head),
    .pop_i   (head_pop)
  );

  psbb_back #(
    .Depth (DISPLAY_WIDTH * DISPLAY_PAGES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .blend_mode_i (cfg_q.blend_mode),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .clearing_o   (clearing),
    .empty_o      (empty),
    .pop_i        (pop),
    .fb_address_o (fb_address_o),
    .fb_value_o   (fb_value_o),
    .last_o       (last_o)
  );

endmodule

[tb/tb_page_shift_bitmap_blitter.sv]
// Self-checking testbench of the page shift bitmap blitter: directed table, then random blits.
module tb_page_shift_bitmap_blitter;

  localparam int FB_COLS      = 84;
  localparam int FB_PAGES     = 6;
  localparam int RANDOM_BYTES = 750;
  localparam int SETTLE_CYC   = 8;
  localparam int DRAIN_CYC    = 20;
  localparam int HOLD_CYC     = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam logic [1:0] BlendKeep = 2'd3;

  typedef struct packed {
    logic [psbb_pkg::AddrW-1:0] addr;
    logic [7:0]                 value;
    logic                       last;
  } fb_write_t;

  typedef struct {
    logic           is_cfg;
    psbb_pkg::cfg_t cfg;
    logic [7:0]     b;
    logic           lic;
    logic           foi;
    int             n_typed;  // -1: expectation comes from the shadow model
    fb_write_t      w;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push, full, empty, pop;
  logic [7:0] src_byte_i;
  logic last_in_column_i, first_of_image_i;
  logic [psbb_pkg::AddrW-1:0] fb_address_o;
  logic [7:0] fb_value_o;
  logic last_o;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  page_shift_bitmap_blitter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .src_byte_i       (src_byte_i),
    .last_in_column_i (last_in_column_i),
    .first_of_image_i (first_of_image_i),
    .empty            (empty),
    .pop              (pop),
    .fb_address_o     (fb_address_o),
    .fb_value_o       (fb_value_o),
    .last_o           (last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the blitter state
  logic [7:0]     fb_shadow [FB_COLS*FB_PAGES];
  psbb_pkg::cfg_t cfg_shadow;
  logic [7:0]     col_cnt;
  logic [3:0]     row_cnt;
  logic [7:0]     carry;
  logic [7:0]     held;
  logic           held_ok;
  logic           blit_taken;

  fb_write_t blit_writes[$];
  fb_write_t fb_writes_q[$];
  dir_row_t  dir_rows[$];

  int  n_errors = 0;
  int  writes_checked = 0;
  int  bytes_sent = 0;
  int  bytes_taken = 0;
  int  n_cfgs = 0;
  int  burst_left = 0;
  bit  push_on = 1'b0;
  bit  hold_off_req = 1'b0;

  task automatic shadow_put(input int col, input int page, input logic [7:0] v);
    int a;
    logic [7:0] nv;
    if (col < 0 || col >= FB_COLS || page < 0 || page >= FB_PAGES) return;
    a = col * FB_PAGES + page;
    case (cfg_shadow.blend_mode)
      psbb_pkg::BlendOr:  nv = fb_shadow[a] | v;
      psbb_pkg::BlendClr: nv = fb_shadow[a] & ~v;
      psbb_pkg::BlendRep: nv = v;
      default:            nv = fb_shadow[a];
    endcase
    fb_shadow[a] = nv;
    blit_writes.push_back('{addr: psbb_pkg::AddrW'(a), value: nv, last: 1'b0});
  endtask

  task automatic predict_blit(input logic [7:0] b, input logic lic, input logic foi);
    int x, y, ny, col, s, off, bo;
    logic col_end;
    blit_writes.delete();
    if (foi) begin
      col_cnt = '0;
      row_cnt = '0;
      carry   = '0;
      held_ok = 1'b0;
    end
    blit_taken = (col_cnt < cfg_shadow.src_width);
    if (!blit_taken) return;
    x = $signed(cfg_shadow.dest_x);
    y = $signed(cfg_shadow.dest_y);
    col = x + int'(col_cnt);
    s = int'(row_cnt);
    col_end = lic || (s + 1 >= int'(cfg_shadow.src_pages));
    if (y >= 0) begin
      off = y / 8;
      bo = y % 8;
      shadow_put(col, off + s, carry | (b << bo));
      if (bo > 0) begin
        carry = b >> (8 - bo);
        if (col_end) shadow_put(col, off + s + 1, carry);
      end else begin
        carry = '0;
      end
    end else begin
      ny = -y;
      off = -(ny / 8);
      bo = ny % 8;
      if (bo == 0) begin
        shadow_put(col, s + off, b);
      end else begin
        if (held_ok) shadow_put(col, s - 1 + off, (held >> bo) | (b << (8 - bo)));
        held = b;
        held_ok = 1'b1;
        if (col_end) shadow_put(col, s + off, b >> bo);
      end
    end
    if (col_end) begin
      col_cnt++;
      row_cnt = '0;
      carry   = '0;
      held_ok = 1'b0;
    end else begin
      row_cnt++;
    end
    if (blit_writes.size() > 0) blit_writes[blit_writes.size()-1].last = 1'b1;
  endtask

  task automatic program_blit(input psbb_pkg::cfg_t c);
    if (push_on) begin
      push <= 1'b0;
      push_on = 1'b0;
    end
    while (fb_writes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= psbb_pkg::CfgDestX;
    cfg_data_i <= c.dest_x;
    @(posedge clk_i);
    cfg_idx_i  <= psbb_pkg::CfgDestY;
    cfg_data_i <= {1'b0, c.dest_y};
    @(posedge clk_i);
    cfg_idx_i  <= psbb_pkg::CfgSrcWidth;
    cfg_data_i <= c.src_width;
    @(posedge clk_i);
    cfg_idx_i  <= psbb_pkg::CfgSrcPages;
    cfg_data_i <= {4'b0, c.src_pages};
    @(posedge clk_i);
    cfg_idx_i  <= psbb_pkg::CfgBlendMode;
    cfg_data_i <= {6'b0, c.blend_mode};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_shadow = c;
    n_cfgs++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lic, input logic foi,
                           input int n_typed, input fb_write_t typed_w);
    src_byte_i       <= b;
    last_in_column_i <= lic;
    first_of_image_i <= foi;
    if (!push_on) begin
      push <= 1'b1;
      push_on = 1'b1;
    end
    do @(posedge clk_i); while (full !== 1'b0);
    bytes_sent++;
    predict_blit(b, lic, foi);
    if (blit_taken) bytes_taken++;
    if (n_typed < 0) begin
      foreach (blit_writes[i]) fb_writes_q.push_back(blit_writes[i]);
    end else if (n_typed > 0) begin
      fb_writes_q.push_back(typed_w);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      push_on = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  function automatic void add_cfg(input int x, input int y, input int w, input int p,
                                  input logic [1:0] m);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg.dest_x = 8'(x);
    r.cfg.dest_y = 7'(y);
    r.cfg.src_width = 8'(w);
    r.cfg.src_pages = 4'(p);
    r.cfg.blend_mode = m;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_item(input logic [7:0] b, input logic lic, input logic foi,
                                   input int n, input int a, input logic [7:0] v);
    dir_row_t r;
    r = '{default: '0};
    r.b = b;
    r.lic = lic;
    r.foi = foi;
    r.n_typed = n;
    r.w = '{addr: psbb_pkg::AddrW'(a), value: v, last: 1'b1};
    dir_rows.push_back(r);
  endfunction

  function automatic psbb_pkg::cfg_t random_cfg(input bit visible);
    psbb_pkg::cfg_t c;
    if (visible) begin
      c.dest_x = 8'($urandom_range(0, 40));
      c.dest_y = 7'($urandom_range(0, 7));
      c.src_width = 8'($urandom_range(16, 128));
      c.src_pages = 4'($urandom_range(1, 6));
      c.blend_mode = 2'($urandom_range(0, 2));
      return c;
    end
    case ($urandom_range(0, 9))
      0:       c.dest_x = 8'h80;
      1:       c.dest_x = 8'h7F;
      2:       c.dest_x = 8'($urandom);
      default: c.dest_x = 8'(int'($urandom_range(0, 95)) - 8);
    endcase
    case ($urandom_range(0, 9))
      0:       c.dest_y = 7'h40;
      1:       c.dest_y = 7'h3F;
      2:       c.dest_y = 7'($urandom);
      default: c.dest_y = 7'(int'($urandom_range(0, 63)) - 16);
    endcase
    case ($urandom_range(0, 11))
      0:       c.src_width = 8'd0;
      1:       c.src_width = 8'hFF;
      2:       c.src_width = 8'd128;
      default: c.src_width = 8'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 11))
      0:       c.src_pages = 4'd0;
      1:       c.src_pages = 4'($urandom_range(9, 15));
      default: c.src_pages = 4'($urandom_range(1, 8));
    endcase
    c.blend_mode = ($urandom_range(0, 9) == 0) ? BlendKeep : 2'($urandom_range(0, 2));
    return c;
  endfunction

  initial begin : stimulus
    psbb_pkg::cfg_t c;
    int goal, tries, cols, depth, full_depth;
    rst_ni           <= 1'b0;
    push             <= 1'b0;
    src_byte_i       <= '0;
    last_in_column_i <= 1'b0;
    first_of_image_i <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= psbb_pkg::CfgDestX;
    cfg_data_i       <= '0;
    foreach (fb_shadow[i]) fb_shadow[i] = '0;
    cfg_shadow = '{dest_x: 8'd0, dest_y: 7'd0, src_width: 8'd1, src_pages: 4'd1,
                   blend_mode: psbb_pkg::BlendOr};
    col_cnt = '0;
    row_cnt = '0;
    carry   = '0;
    held    = '0;
    held_ok = 1'b0;

    add_cfg(0, 0, 4, 2, psbb_pkg::BlendOr);
    add_item(8'hFF, 1'b0, 1'b1, 1, 0, 8'hFF);
    add_item(8'h00, 1'b1, 1'b0, 1, 1, 8'h00);
    add_item(8'h81, 1'b1, 1'b0, 1, 6, 8'h81);
    // right edge, clear mode: zero framebuffer stays zero, column 84 is clipped
    add_cfg(83, 0, 128, 8, psbb_pkg::BlendClr);
    add_item(8'h0F, 1'b0, 1'b1, 1, 498, 8'h00);
    add_item(8'hFF, 1'b1, 1'b0, 1, 499, 8'h00);
    add_item(8'hAA, 1'b1, 1'b0, 0, 0, 8'h00);
    // most negative x, most positive y; second byte is past src_width
    add_cfg(-128, 63, 1, 8, psbb_pkg::BlendRep);
    add_item(8'h5A, 1'b1, 1'b1, 0, 0, 8'h00);
    add_item(8'h33, 1'b1, 1'b0, 0, 0, 8'h00);
    // y = -64 pushes every page above the display
    add_cfg(5, -64, 2, 8, psbb_pkg::BlendOr);
    add_item(8'hFF, 1'b0, 1'b1, 0, 0, 8'h00);
    add_item(8'hFF, 1'b1, 1'b0, 0, 0, 8'h00);
    // downward shift with carry row
    add_cfg(2, 3, 2, 2, psbb_pkg::BlendOr);
    add_item(8'hE5, 1'b0, 1'b1, -1, 0, 8'h00);
    add_item(8'h3C, 1'b0, 1'b0, -1, 0, 8'h00);
    // upward shift with held byte, then a one-byte column
    add_cfg(2, -5, 2, 3, psbb_pkg::BlendRep);
    add_item(8'h81, 1'b0, 1'b1, -1, 0, 8'h00);
    add_item(8'hF0, 1'b0, 1'b0, -1, 0, 8'h00);
    add_item(8'h0F, 1'b0, 1'b0, -1, 0, 8'h00);
    add_item(8'h7E, 1'b1, 1'b0, -1, 0, 8'h00);
    // blend selector three keeps the framebuffer byte
    add_cfg(0, 0, 1, 1, BlendKeep);
    add_item(8'h55, 1'b0, 1'b1, 1, 0, 8'hFF);
    // src_pages of zero acts as one
    add_cfg(10, 8, 3, 0, psbb_pkg::BlendOr);
    add_item(8'h12, 1'b0, 1'b1, 1, 61, 8'h12);
    // src_width of zero: everything ignored
    add_cfg(10, 8, 0, 1, psbb_pkg::BlendOr);
    add_item(8'hC3, 1'b1, 1'b1, 0, 0, 8'h00);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) program_blit(dir_rows[i].cfg);
      else send_byte(dir_rows[i].b, dir_rows[i].lic, dir_rows[i].foi,
                     dir_rows[i].n_typed, dir_rows[i].w);
    end

    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      c = random_cfg(!hold_off_req);
      program_blit(c);
      hold_off_req = 1'b1;
      full_depth = (c.src_pages == 0) ? 1 : int'(c.src_pages);
      tries = bytes_sent + $urandom_range(30, 90);
      for (int it = 0; it < 150 && bytes_sent < tries; it++) begin
        if ($urandom_range(0, 6) == 0) begin
          send_byte(8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0, -1, '0);
        end else begin
          cols = $urandom_range(1, 10);
          for (int k = 0; k < cols; k++) begin
            depth = ($urandom_range(0, 4) == 0) ? $urandom_range(1, full_depth) : full_depth;
            for (int r = 0; r < depth; r++)
              send_byte(8'($urandom),
                        (r == depth - 1) && (depth < full_depth || $urandom_range(0, 1)),
                        k == 0 && r == 0, -1, '0);
          end
        end
      end
    end

    if (push_on) push <= 1'b0;
    while (fb_writes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("%0d source bytes sent (%0d blitted) under %0d register settings",
             bytes_sent, bytes_taken, n_cfgs);
    $display("%0d framebuffer write transactions compared", writes_checked);
    if (n_errors == 0 && fb_writes_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin : result_drain
    logic [15:0] cyc;
    bit held_off;
    cyc = '0;
    held_off = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_off_req && !held_off) begin
        // long back-pressure: sender keeps pushing until the block fills
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
      end else begin
        case (cyc[7:6])
          2'd0:    pop <= 1'b1;
          2'd1:    pop <= 1'($urandom_range(0, 1));
          2'd2:    pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (cyc[2:0] != 3'd0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : write_check
    fb_write_t exp_w;
    if (pop === 1'b1 && empty === 1'b0) begin
      if (fb_writes_q.size() == 0) begin
        $error("framebuffer write with nothing expected: address %0d value %0h",
               fb_address_o, fb_value_o);
        n_errors++;
      end else begin
        exp_w = fb_writes_q.pop_front();
        writes_checked++;
        if (fb_address_o !== exp_w.addr) begin
          $error("fb_address: expected %0d, actual %0d", exp_w.addr, fb_address_o);
          n_errors++;
        end
        if (fb_value_o !== exp_w.value) begin
          $error("fb_value: expected %0h, actual %0h", exp_w.value, fb_value_o);
          n_errors++;
        end
        if (last_o !== exp_w.last) begin
          $error("last: expected %0b, actual %0b", exp_w.last, last_o);
          n_errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0)) stuck = 0;
      else stuck++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/psbb_pkg.sv
rtl/psbb_ram.sv
rtl/psbb_front.sv
rtl/psbb_opq.sv
rtl/psbb_back.sv
rtl/page_shift_bitmap_blitter.sv
tb/tb_page_shift_bitmap_blitter.sv
